>>> design/ths_pkg.sv
// Shared types and constants for the timestamped history store.
`default_nettype none

package ths_pkg;

  localparam int unsigned HistDepth  = 1024;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_ORDER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_CMP
  } back_state_e;

  typedef struct packed {
    logic              kind;
    logic signed [63:0] item_value;
    logic signed [63:0] stamp;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic signed [63:0] value_at_time;
    logic               value_matches;
    logic signed [63:0] current_value;
    logic signed [63:0] min_value;
    logic signed [63:0] max_value;
    logic [10:0]        entry_count;
  } result_t;

  typedef struct packed {
    kind_e              op;
    logic signed [63:0] item_value;
    logic signed [63:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

`default_nettype wire

>>> design/ths_front.sv
// Front end: takes items in, classifies them and queues them for the back end.
`default_nettype none

module ths_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ths_pkg::item_t    item_i,
  input  logic              pop_i,
  output ths_pkg::cmd_slot_t head_o
);
  import ths_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FW = $clog2(QueueDepth + 1);
  localparam logic [FW-1:0] FullFill = FW'(QueueDepth);
  localparam logic [PW-1:0] LastPtr  = PW'(QueueDepth - 1);

  cmd_t          slot_q [QueueDepth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          accept;
  cmd_t          cmd_in;

  assign busy   = (fill_q == FullFill);
  assign accept = start && !busy;

  always_comb begin
    cmd_in.op         = item_i.kind ? KIND_QUERY : KIND_APPEND;
    cmd_in.item_value = item_i.item_value;
    cmd_in.stamp      = item_i.stamp;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({accept, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (fill_q != '0))
    else $error("queue popped while empty");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("queue fill exceeds its depth");

  a_head_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (fill_q == '0) && !pop_i) |=> head_o.valid)
    else $error("transfer into empty queue not visible at head");

endmodule

`default_nettype wire

>>> design/ths_back.sv
// Back end: history memories, running statistics and the binary search sequencer.
`default_nettype none

module ths_back #(
  parameter int unsigned HISTORY_DEPTH = ths_pkg::HistDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ths_pkg::cmd_slot_t head_i,
  output logic               pop_o,
  output logic               done_o,
  output ths_pkg::result_t   result_o
);
  import ths_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] DepthCnt = CW'(HISTORY_DEPTH);

  logic signed [63:0] stamp_mem [HISTORY_DEPTH];
  logic signed [63:0] value_mem [HISTORY_DEPTH];

  back_state_e        state_q, state_d;
  kind_e              op_q, op_d;
  logic signed [63:0] item_value_q, item_value_d;
  logic signed [63:0] stamp_q, stamp_d;
  logic [CW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic signed [63:0] cand_q, cand_d;
  logic [CW-1:0]      count_q, count_d;
  logic signed [63:0] last_stamp_q, last_stamp_d;
  logic signed [63:0] cur_value_q, cur_value_d;
  logic signed [63:0] min_q, min_d;
  logic signed [63:0] max_q, max_d;
  logic               done_q, done_d;
  result_t            result_q, result_d;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic signed [63:0] rd_stamp_q;
  logic signed [63:0] rd_value_q;
  logic [CW-1:0]      span;
  logic [CW-1:0]      mid;

  assign span    = hi_q - lo_q;
  assign mid     = lo_q + (span >> 1);
  assign rd_addr = mid[AW-1:0];
  assign wr_addr = count_q[AW-1:0];

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    item_value_d = item_value_q;
    stamp_d      = stamp_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    cand_d       = cand_q;
    count_d      = count_q;
    last_stamp_d = last_stamp_q;
    cur_value_d  = cur_value_q;
    min_d        = min_q;
    max_d        = max_q;
    done_d       = 1'b0;
    result_d     = result_q;
    pop_o        = 1'b0;
    wr_en        = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (head_i.valid) begin
          pop_o        = 1'b1;
          op_d         = head_i.cmd.op;
          item_value_d = head_i.cmd.item_value;
          stamp_d      = head_i.cmd.stamp;
          lo_d         = '0;
          hi_d         = count_q;
          cand_d       = '0;
          state_d      = BK_EXEC;
        end
      end

      BK_EXEC: begin
        if (op_q == KIND_APPEND) begin
          result_d.found         = 1'b0;
          result_d.value_at_time = '0;
          result_d.value_matches = 1'b0;
          if (count_q == DepthCnt) begin
            result_d.status = STATUS_FULL;
          end else if ((count_q != '0) && (stamp_q < last_stamp_q)) begin
            result_d.status = STATUS_ORDER;
          end else begin
            result_d.status = STATUS_OK;
            wr_en           = 1'b1;
            count_d         = count_q + 1'b1;
            last_stamp_d    = stamp_q;
            cur_value_d     = item_value_q;
            if (count_q == '0) begin
              min_d = item_value_q;
              max_d = item_value_q;
            end else begin
              if (item_value_q < min_q) begin
                min_d = item_value_q;
              end
              if (max_q < item_value_q) begin
                max_d = item_value_q;
              end
            end
          end
          done_d  = 1'b1;
          state_d = BK_IDLE;
        end else if (lo_q < hi_q) begin
          // The probe at mid is read from both memories on this edge.
          state_d = BK_CMP;
        end else begin
          result_d.status        = STATUS_OK;
          result_d.found         = (lo_q != '0);
          result_d.value_at_time = cand_q;
          result_d.value_matches = (lo_q != '0) && (cand_q == item_value_q);
          done_d                 = 1'b1;
          state_d                = BK_IDLE;
        end
        result_d.current_value = cur_value_d;
        result_d.min_value     = min_d;
        result_d.max_value     = max_d;
        result_d.entry_count   = 11'(count_d);
      end

      BK_CMP: begin
        // Searching for the first entry stamped after the query time; the
        // entry just below it is the latest one at or before that time.
        if (stamp_q < rd_stamp_q) begin
          hi_d = mid;
        end else begin
          lo_d   = mid + 1'b1;
          cand_d = rd_value_q;
        end
        state_d = BK_EXEC;
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      cur_value_q <= '0;
      min_q       <= '0;
      max_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_value_q <= cur_value_d;
      min_q       <= min_d;
      max_q       <= max_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    item_value_q <= item_value_d;
    stamp_q      <= stamp_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    cand_q       <= cand_d;
    last_stamp_q <= last_stamp_d;
    result_q     <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= stamp_q;
      value_mem[wr_addr] <= item_value_q;
    end
    rd_stamp_q <= stamp_mem[rd_addr];
    rd_value_q <= value_mem[rd_addr];
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count exceeds history depth");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CMP) |-> ((lo_q < hi_q) && (hi_q <= count_q)))
    else $error("search probe outside stored entries");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> ((state_q == BK_IDLE) && head_i.valid))
    else $error("command taken while back end busy");

endmodule

`default_nettype wire

>>> design/timestamped_history_store.sv
// Flow: the back end pops a command from the queue head while idle, executes it in BK_EXEC
// and registers the result; a query alternates BK_EXEC and BK_CMP for each search probe.
// The back end takes no new command until the current one is done; a two-entry queue takes
// items meanwhile.
// Results appear on done_o for one cycle and cannot be stalled.
// Reset clears the count, the running statistics and the queue; the memories are not cleared.
`default_nettype none

module timestamped_history_store #(
  parameter int unsigned HISTORY_DEPTH = ths_pkg::HistDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ths_pkg::item_t   item_i,
  output logic             done_o,
  output ths_pkg::result_t result_o
);
  import ths_pkg::*;

  cmd_slot_t head;
  logic      pop;

  ths_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .pop_i  (pop),
    .head_o (head)
  );

  ths_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
